@@ rtl/hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv_pkg
// shared widths, sector codes and fixed-point helpers of the hsv to rgb path
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int HUE_W   = 16;
    localparam int LEVEL_W = 14;
    localparam int CHAN_W  = 8;
    localparam int IN_W    = 48;   // 44 payload bits padded to whole bytes
    localparam int OUT_W   = 24;

    localparam int UNIT_W  = 13;   // clamped Q.12 level, 0..4096
    localparam int FRAC_W  = 16;   // hue fraction inside one sector
    localparam int FACT_W  = 29;   // Q.28 factor, 0..2^28
    localparam int CH40_W  = 41;   // Q.40 channel, 0..2^40

    localparam logic [UNIT_W-1:0] ONE_Q12 = 13'd4096;
    localparam logic [FACT_W-1:0] ONE_Q28 = 29'h1000_0000;
    localparam logic [FRAC_W:0]   ONE_Q16 = 17'h1_0000;

    typedef logic [2:0] t_sector;

    localparam t_sector SECTOR_RED_YEL = 3'd0;
    localparam t_sector SECTOR_YEL_GRN = 3'd1;
    localparam t_sector SECTOR_GRN_CYN = 3'd2;
    localparam t_sector SECTOR_CYN_BLU = 3'd3;
    localparam t_sector SECTOR_BLU_MAG = 3'd4;

    // negative -> 0, above 1.0 -> 1.0
    function automatic logic [UNIT_W-1:0] clamp_level(input logic [LEVEL_W-1:0] raw);
        logic [UNIT_W-1:0] mag;
        mag = raw[UNIT_W-1:0];
        if (raw[LEVEL_W-1]) begin
            return '0;
        end else if (mag > ONE_Q12) begin
            return ONE_Q12;
        end else begin
            return mag;
        end
    endfunction

    // round c*255 half up out of Q.40 and saturate
    function automatic logic [CHAN_W-1:0] to_byte(input logic [CH40_W-1:0] c40);
        logic [CH40_W+7:0] sum;
        logic [8:0]        whole;
        sum   = {c40, 8'b0} - {8'b0, c40} + {9'b0, 1'b1, 39'b0};
        whole = sum[CH40_W+7:40];
        if (whole > 9'd255) begin
            return 8'hFF;
        end else begin
            return whole[CHAN_W-1:0];
        end
    endfunction

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// streaming hsv to 8-bit rgb conversion, five register stages
// ----------------------------------------------------------------------------
// Takes one hue/saturation/value item per cycle, unless the output stalls,
// and returns one rgb item for each, in order. The path is split into
// five stages: level clamp and hue*6 sector split, the saturation-by-fraction
// products, the value products giving p, q and t, the sector channel select,
// and the round-to-byte step. Each stage holds its item while the next one is
// full and stalled, and empty stages fill up, so a stall on the output side
// loses nothing and the input keeps flowing until all five stages are full.
// Hue is an unsigned fraction of a turn; saturation and value are signed Q.12
// clamped to 0..1.0.
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // hue_turn[15:0], sat_level[29:16], val_level[43:30], zero pad
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int NSTG = 5;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] stg_en;

    // stage k loads when it is empty or its item moves on
    always_comb begin
        stg_en[NSTG] = !r_vld[NSTG] || i_m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign o_s_axis_tready = stg_en[1];
    assign o_m_axis_tvalid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: clamp and sector split
    logic [HUE_W-1:0]   in_hue;
    logic [HUE_W+2:0]   hue6;
    logic [UNIT_W-1:0]  r_s1_sat, r_s1_val;
    t_sector            r_s1_sector;
    logic [FRAC_W-1:0]  r_s1_frac;

    assign in_hue = i_s_axis_tdata[HUE_W-1:0];
    assign hue6   = {1'b0, in_hue, 2'b0} + {2'b0, in_hue, 1'b0};

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s1_sat    <= clamp_level(i_s_axis_tdata[HUE_W+LEVEL_W-1:HUE_W]);
            r_s1_val    <= clamp_level(i_s_axis_tdata[HUE_W+2*LEVEL_W-1:HUE_W+LEVEL_W]);
            r_s1_sector <= hue6[HUE_W+2:HUE_W];
            r_s1_frac   <= hue6[FRAC_W-1:0];
        end
    end

    // stage 2: factors 1-s, 1-s*f and 1-s*(1-f) as Q.28
    logic [FRAC_W:0]    inv_frac;
    logic [FACT_W-1:0]  sat_frac;
    logic [FACT_W:0]    sat_inv;
    logic [FACT_W-1:0]  r_s2_fp, r_s2_fq, r_s2_ft;
    logic [UNIT_W-1:0]  r_s2_val;
    t_sector            r_s2_sector;

    assign inv_frac = ONE_Q16 - {1'b0, r_s1_frac};
    assign sat_frac = r_s1_sat * r_s1_frac;
    assign sat_inv  = r_s1_sat * inv_frac;

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s2_fp     <= {ONE_Q12 - r_s1_sat, 16'b0};
            r_s2_fq     <= ONE_Q28 - sat_frac;
            r_s2_ft     <= ONE_Q28 - sat_inv[FACT_W-1:0];
            r_s2_val    <= r_s1_val;
            r_s2_sector <= r_s1_sector;
        end
    end

    // stage 3: p, q, t and v as Q.40
    logic [UNIT_W+FACT_W-1:0] prod_p, prod_q, prod_t;
    logic [CH40_W-1:0]        r_s3_p, r_s3_q, r_s3_t, r_s3_v;
    t_sector                  r_s3_sector;

    assign prod_p = r_s2_val * r_s2_fp;
    assign prod_q = r_s2_val * r_s2_fq;
    assign prod_t = r_s2_val * r_s2_ft;

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s3_p      <= prod_p[CH40_W-1:0];
            r_s3_q      <= prod_q[CH40_W-1:0];
            r_s3_t      <= prod_t[CH40_W-1:0];
            r_s3_v      <= {r_s2_val, 28'b0};
            r_s3_sector <= r_s2_sector;
        end
    end

    // stage 4: channel order by sector
    logic [CH40_W-1:0] n_red, n_grn, n_blu;
    logic [CH40_W-1:0] r_s4_red, r_s4_grn, r_s4_blu;

    always_comb begin
        case (r_s3_sector)
            SECTOR_RED_YEL: begin
                n_red = r_s3_v; n_grn = r_s3_t; n_blu = r_s3_p;
            end
            SECTOR_YEL_GRN: begin
                n_red = r_s3_q; n_grn = r_s3_v; n_blu = r_s3_p;
            end
            SECTOR_GRN_CYN: begin
                n_red = r_s3_p; n_grn = r_s3_v; n_blu = r_s3_t;
            end
            SECTOR_CYN_BLU: begin
                n_red = r_s3_p; n_grn = r_s3_q; n_blu = r_s3_v;
            end
            SECTOR_BLU_MAG: begin
                n_red = r_s3_t; n_grn = r_s3_p; n_blu = r_s3_v;
            end
            default: begin
                n_red = r_s3_v; n_grn = r_s3_p; n_blu = r_s3_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_s4_red <= n_red;
            r_s4_grn <= n_grn;
            r_s4_blu <= n_blu;
        end
    end

    // stage 5: round to bytes, output register
    logic [OUT_W-1:0] r_s5_rgb;

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_s5_rgb <= {to_byte(r_s4_blu), to_byte(r_s4_grn), to_byte(r_s4_red)};
        end
    end

    assign o_m_axis_tdata = r_s5_rgb;

endmodule

@@ test/hsv_rgb_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_rgb_checker
// watches both item channels of the hsv to rgb converter, works out the rgb
// item that each accepted hsv item must give, and compares results in order
// ----------------------------------------------------------------------------
module hsv_rgb_checker
    import hsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    // hue_turn[15:0], sat_level[29:16], val_level[43:30], zero pad
    input  logic [IN_W-1:0]  i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    input  logic [OUT_W-1:0] i_out_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_checked
);

    localparam longint unsigned UNIT    = 4096;   // 1.0 in Q.12
    localparam longint unsigned TURN    = 65536;  // 1.0 in Q0.16
    localparam int              MAX_LOG = 20;

    // first member lands in the top bits, so red sits at [7:0]
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    t_rgb  expected_rgb[$];
    int    fail_total    = 0;
    int    checked_total = 0;
    string chan_name[3]  = '{"red", "green", "blue"};

    assign o_fail_count = fail_total;

    initial begin
        o_pending         = 0;
        o_results_checked = 0;
    end

    task automatic report_failure(input string msg);
        if (fail_total < MAX_LOG) begin
            $display("%0t: %s", $time, msg);
        end
        fail_total++;
    endtask

    // negative levels read as zero, anything above 1.0 as 1.0
    function automatic longint unsigned clamp_unit(input logic [LEVEL_W-1:0] raw);
        if (raw[LEVEL_W-1]) begin
            return 0;
        end
        if (raw > 14'd4096) begin
            return UNIT;
        end
        return raw;
    endfunction

    // q.40 channel times 255, half up, saturated
    function automatic logic [CHAN_W-1:0] round_to_byte(input longint unsigned c40);
        longint unsigned whole;
        whole = (c40 * 255 + (64'd1 << 39)) >> 40;
        return (whole > 255) ? 8'hFF : whole[CHAN_W-1:0];
    endfunction

    function automatic t_rgb predict_rgb(input logic [IN_W-1:0] word);
        longint unsigned hue, sat, val, hue6, frac, full, vv, p, q, t, r, g, b;
        t_sector         sector;
        t_rgb            rgb;
        hue    = word[HUE_W-1:0];
        sat    = clamp_unit(word[HUE_W +: LEVEL_W]);
        val    = clamp_unit(word[HUE_W+LEVEL_W +: LEVEL_W]);
        hue6   = hue * 6;
        sector = hue6[18:16];
        frac   = hue6 & (TURN - 1);
        full   = UNIT << 16;
        vv     = val * full;
        p      = val * ((UNIT - sat) << 16);
        q      = val * (full - sat * frac);
        t      = val * (full - sat * (TURN - frac));
        case (sector)
            SECTOR_RED_YEL: begin r = vv; g = t;  b = p;  end
            SECTOR_YEL_GRN: begin r = q;  g = vv; b = p;  end
            SECTOR_GRN_CYN: begin r = p;  g = vv; b = t;  end
            SECTOR_CYN_BLU: begin r = p;  g = q;  b = vv; end
            SECTOR_BLU_MAG: begin r = t;  g = p;  b = vv; end
            default: begin r = vv; g = p; b = q; end
        endcase
        rgb.red   = round_to_byte(r);
        rgb.green = round_to_byte(g);
        rgb.blue  = round_to_byte(b);
        return rgb;
    endfunction

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                expected_rgb.push_back(predict_rgb(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_rgb.size() == 0) begin
                    report_failure($sformatf("rgb item %06x with nothing expected", got));
                end else begin
                    want = expected_rgb.pop_front();
                    for (int c = 0; c < 3; c++) begin
                        if (got[c*CHAN_W +: CHAN_W] !== want[c*CHAN_W +: CHAN_W]) begin
                            report_failure($sformatf("result %0d %s: got %0d, expected %0d",
                                checked_total, chan_name[c],
                                got[c*CHAN_W +: CHAN_W], want[c*CHAN_W +: CHAN_W]));
                        end
                    end
                    checked_total++;
                end
            end
        end
        o_pending         <= expected_rgb.size();
        o_results_checked <= checked_total;
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the hsv to rgb converter
// ----------------------------------------------------------------------------
// Sends a directed set of hsv items (sector edges, hue wrap, grey, clamped
// and negative levels, a half-way rounding case) and then random items with
// random gaps on the input and random back-pressure on the output, including
// one long output hold that fills the pipeline. The checker beside the block
// predicts every rgb item and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import hsv_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int LONG_HOLD    = 300;
    localparam int PAD_W        = IN_W - HUE_W - 2 * LEVEL_W;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_valid;
    logic             s_ready;
    logic [IN_W-1:0]  s_data;
    logic             m_valid;
    logic             m_ready;
    logic [OUT_W-1:0] m_data;

    int fail_count;
    int pending;
    int results_checked;
    int items_sent     = 0;
    int directed_items = 0;
    bit long_hold_done = 0;

    hsv_to_rgb_converter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    hsv_rgb_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (s_valid),
        .i_in_ready        (s_ready),
        .i_in_data         (s_data),
        .i_out_valid       (m_valid),
        .i_out_ready       (m_ready),
        .i_out_data        (m_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return $urandom_range(0, 4096);
        end else if (roll < 75) begin
            return $urandom_range(0, 1) ? 14'd4096 : 14'd0;
        end
        return $urandom;   // whole signed range, clamps both ways
    endfunction

    // mostly any hue, else at or just around the first hue of a sector
    function automatic logic [HUE_W-1:0] pick_hue();
        int k;
        if ($urandom_range(0, 99) < 80) begin
            return $urandom;
        end
        k = $urandom_range(0, 5);
        return (k * 65536 + 5) / 6 + $urandom_range(0, 4) - 2;
    endfunction

    task automatic send_hsv(input logic [HUE_W-1:0] hue, input logic [LEVEL_W-1:0] sat,
                            input logic [LEVEL_W-1:0] val, input int gap);
        s_valid <= 1'b1;
        s_data  <= {{PAD_W{1'b0}}, val, sat, hue};
        do begin
            @(posedge i_clk);
        end while (!s_ready);
        items_sent++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver: runs of ready, random stalls, one long hold while items keep coming
    initial begin
        int run_len;
        int stall;
        m_ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            m_ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
            repeat (run_len) @(posedge i_clk);
            if (!long_hold_done && items_sent >= 400) begin
                stall          = LONG_HOLD;
                long_hold_done = 1;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d rgb items still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int gap;
        s_valid <= 1'b0;
        s_data  <= '0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pure red, then both sides of every sector edge, then hue wrap
        send_hsv(16'h0000, 14'd4096, 14'd4096, pick_gap());
        for (int k = 1; k < 6; k++) begin
            send_hsv((k * 65536 + 5) / 6,     14'd4096, 14'd4096, pick_gap());
            send_hsv((k * 65536 + 5) / 6 - 1, 14'd4096, 14'd4096, pick_gap());
        end
        send_hsv(16'hFFFF, 14'd4096, 14'd4096, pick_gap());
        // grey; half of full scale lands exactly on a rounding midpoint
        send_hsv(16'd12345, 14'd0, 14'd4096, pick_gap());
        send_hsv(16'd40000, 14'd0, 14'd2048, pick_gap());
        // negative and over-range levels
        send_hsv(16'd5000,  14'h3FFF, 14'd4096, pick_gap());   // sat -1
        send_hsv(16'd20000, 14'h2000, 14'h1FFF, pick_gap());   // sat most negative
        send_hsv(16'd30000, 14'd4097, 14'd4097, pick_gap());
        send_hsv(16'd50000, 14'h1FFF, 14'h3FFF, pick_gap());   // val -1
        send_hsv(16'd60000, 14'd4096, 14'd0, pick_gap());
        send_hsv(16'd25000, 14'd3000, 14'h2000, pick_gap());   // val most negative
        directed_items = items_sent;

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // every fourth stretch of items goes back to back
            gap = ((i / 150) % 4 == 1) ? 0 : pick_gap();
            send_hsv(pick_hue(), pick_level(), pick_level(), gap);
        end
        s_valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("converted %0d hsv items (%0d directed, %0d random), %0d rgb items checked",
                 items_sent, directed_items, items_sent - directed_items, results_checked);
        $display("covered all six sectors, clamped levels and a %0d-cycle output hold",
                 LONG_HOLD);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
